[hdl/c2s_pkg.sv]
package c2s_pkg;

	localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_Q60     = PI_Q60 >> 1;
	localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;

	localparam int ISQ_W    = 32;
	localparam int ISQ_LAT  = ISQ_W + 1;
	localparam int DEG_LAT  = 7;
	localparam int DEG_W    = 48;
	localparam int NORM_LAT = 7;

	// arctan(2^-idx) in radians, Q.60: pi/4 for idx 0, else by its power series
	function automatic logic [63:0] atan_q60(input int idx);
		logic [63:0] acc;
		logic [63:0] term;
		int k;
		int e;
		acc = '0;
		if (idx == 0) begin
			acc = PI_Q60 >> 2;
		end else begin
			for (k = 0; k < 32; k++) begin
				e = idx * (2 * k + 1);
				if (e <= 60) begin
					term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
					if ((k % 2) == 0)
						acc = acc + term;
					else
						acc = acc - term;
				end
			end
		end
		return acc;
	endfunction

endpackage

[hdl/cartesian_to_spherical_degrees_core.sv]
// done follows a taken start through vld_s1, the u_vh_dly delay line and the done register.
// Throughput: one point per cycle; busy stays low and results cannot be held off.
// The depth is set by the polar path: normalizer, rho square root, CORDIC, degree scaling.
// Reset: arst_n clears vld_s1, the delay lines and done at once; other registers, polar_valid too, carry no reset.
module cartesian_to_spherical_degrees_core import c2s_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic               has_z,
	output logic               done,
	output logic        [31:0] radius,
	output logic        [24:0] azimuth_deg,
	output logic        [23:0] polar_deg,
	output logic               polar_valid
);

	localparam int LC    = 7 + CORDIC_STEPS;
	localparam int TOTAL = 51 + LC;
	localparam logic signed [DEG_W-1:0] DEG360 = DEG_W'(360) << FRAC_BITS;
	localparam logic signed [DEG_W-1:0] DEG180 = DEG_W'(180) << FRAC_BITS;

	assign busy = 1'b0;

	logic signed [31:0] x_s1, y_s1, z_s1;
	logic        [31:0] ax_s1, ay_s1, az_s1;
	logic               vld_s1, hz_s1;
	logic signed [31:0] zin;

	assign zin = has_z ? coord_z : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		x_s1  <= coord_x;
		y_s1  <= coord_y;
		z_s1  <= zin;
		hz_s1 <= has_z;
		ax_s1 <= coord_x[31] ? 32'(-coord_x) : 32'(coord_x);
		ay_s1 <= coord_y[31] ? 32'(-coord_y) : 32'(coord_y);
		az_s1 <= zin[31] ? 32'(-zin) : 32'(zin);
	end

	// radius
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;
	logic [31:0] rad_raw, rad_out;

	always_ff @(posedge clk) begin
		sqx_s2 <= ax_s1 * ax_s1;
		sqy_s2 <= ay_s1 * ay_s1;
		sqz_s2 <= az_s1 * az_s1;
	end

	c2s_isqrt u_rad_sqrt (
		.clk  (clk),
		.in_a (sqx_s2),
		.in_b (sqy_s2),
		.in_c (sqz_s2),
		.root (rad_raw)
	);

	c2s_delay #(.W(32), .D(TOTAL - 35)) u_rad_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (rad_raw),
		.dout   (rad_out)
	);

	// azimuth
	logic signed [34:0] azx_s2, azy_s2;
	logic               xneg_s2, ypos_s2;
	logic        [1:0]  azf_d;
	logic signed [63:0] az_ang, az_off;
	logic signed [DEG_W-1:0] az_deg, az_fix_s1;
	logic        [24:0] az_out;

	always_ff @(posedge clk) begin
		xneg_s2 <= x_s1[31];
		ypos_s2 <= !y_s1[31];
		azx_s2  <= 35'(ax_s1);
		azy_s2  <= x_s1[31] ? -35'(y_s1) : 35'(y_s1);
	end

	c2s_cordic #(.STEPS(CORDIC_STEPS)) u_az_cordic (
		.clk   (clk),
		.in_xv (azx_s2),
		.in_yv (azy_s2),
		.ang   (az_ang)
	);

	c2s_delay #(.W(2), .D(LC)) u_azf_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    ({xneg_s2, ypos_s2}),
		.dout   (azf_d)
	);

	assign az_off = !azf_d[1] ? 64'sd0 :
	                azf_d[0]  ? $signed(PI_Q60) : -$signed(PI_Q60);

	c2s_deg #(.FRAC_BITS(FRAC_BITS)) u_az_deg (
		.clk    (clk),
		.ang    (az_ang),
		.offset (az_off),
		.deg    (az_deg)
	);

	always_ff @(posedge clk) begin
		az_fix_s1 <= az_deg[DEG_W-1] ? az_deg + DEG360 : az_deg;
	end

	c2s_delay #(.W(25), .D(41)) u_az_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (az_fix_s1[24:0]),
		.dout   (az_out)
	);

	// polar: scale so the largest magnitude lands just above 2^30
	logic signed [33:0] px_s [NORM_LAT];
	logic signed [33:0] py_s [NORM_LAT];
	logic signed [33:0] pz_s [NORM_LAT];
	logic        [32:0] pm_s [NORM_LAT];
	logic        [31:0] mxy;

	assign mxy = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;

	always_ff @(posedge clk) begin
		px_s[0] <= 34'(x_s1);
		py_s[0] <= 34'(y_s1);
		pz_s[0] <= 34'(z_s1);
		pm_s[0] <= 33'((az_s1 > mxy) ? az_s1 : mxy);
	end

	for (genvar t = 0; t < NORM_LAT - 1; t++) begin : g_pnorm
		localparam int SH  = (t < NORM_LAT - 2) ? (16 >> t) : 1;
		localparam int LIM = (t < NORM_LAT - 2) ? (30 - SH) : 30;
		always_ff @(posedge clk) begin
			if (pm_s[t] <= (33'd1 << LIM)) begin
				px_s[t+1] <= px_s[t] <<< SH;
				py_s[t+1] <= py_s[t] <<< SH;
				pz_s[t+1] <= pz_s[t] <<< SH;
				pm_s[t+1] <= pm_s[t] << SH;
			end else begin
				px_s[t+1] <= px_s[t];
				py_s[t+1] <= py_s[t];
				pz_s[t+1] <= pz_s[t];
				pm_s[t+1] <= pm_s[t];
			end
		end
	end

	logic        [31:0] pax_s8, pay_s8;
	logic        [63:0] psx_s9, psy_s9;
	logic        [31:0] rho;
	logic        [33:0] zs_d;
	logic signed [33:0] zs_al;
	logic signed [34:0] pxv_s1, pyv_s1;
	logic               negz_s1, negz_d;
	logic signed [63:0] po_ang, po_off;
	logic signed [DEG_W-1:0] po_deg;
	logic        [1:0]  vh_d;

	always_ff @(posedge clk) begin
		pax_s8 <= px_s[NORM_LAT-1][33] ? 32'(-px_s[NORM_LAT-1]) : 32'(px_s[NORM_LAT-1]);
		pay_s8 <= py_s[NORM_LAT-1][33] ? 32'(-py_s[NORM_LAT-1]) : 32'(py_s[NORM_LAT-1]);
		psx_s9 <= pax_s8 * pax_s8;
		psy_s9 <= pay_s8 * pay_s8;
	end

	c2s_isqrt u_rho_sqrt (
		.clk  (clk),
		.in_a (psx_s9),
		.in_b (psy_s9),
		.in_c (64'd0),
		.root (rho)
	);

	c2s_delay #(.W(34), .D(ISQ_LAT + 2)) u_zs_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (pz_s[NORM_LAT-1]),
		.dout   (zs_d)
	);

	assign zs_al = $signed(zs_d);

	always_ff @(posedge clk) begin
		negz_s1 <= zs_al[33];
		if (!zs_al[33]) begin
			pxv_s1 <= 35'(zs_al);
			pyv_s1 <= 35'(rho);
		end else begin
			pxv_s1 <= 35'(rho);
			pyv_s1 <= -35'(zs_al);
		end
	end

	c2s_cordic #(.STEPS(CORDIC_STEPS)) u_po_cordic (
		.clk   (clk),
		.in_xv (pxv_s1),
		.in_yv (pyv_s1),
		.ang   (po_ang)
	);

	c2s_delay #(.W(1), .D(LC)) u_negz_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (negz_s1),
		.dout   (negz_d)
	);

	assign po_off = negz_d ? $signed(HALF_PI_Q60) : 64'sd0;

	c2s_deg #(.FRAC_BITS(FRAC_BITS)) u_po_deg (
		.clk    (clk),
		.ang    (po_ang),
		.offset (po_off),
		.deg    (po_deg)
	);

	c2s_delay #(.W(2), .D(TOTAL - 1)) u_vh_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    ({vld_s1, hz_s1}),
		.dout   (vh_d)
	);

	logic [23:0] po_clamp;

	always_comb begin
		priority if (po_deg[DEG_W-1])
			po_clamp = '0;
		else if (po_deg > DEG180)
			po_clamp = DEG180[23:0];
		else
			po_clamp = po_deg[23:0];
	end

	always_ff @(posedge clk) begin
		polar_deg   <= vh_d[0] ? po_clamp : '0;
		polar_valid <= vh_d[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vh_d[1];
	end

	// one more register on radius and azimuth to line up with the polar clamp stage
	always_ff @(posedge clk) begin
		radius      <= rad_out;
		azimuth_deg <= az_out;
	end

endmodule

[hdl/c2s_delay.sv]
module c2s_delay import c2s_pkg::*; #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++)
				sr_q[i] <= '0;
		end else begin
			sr_q[0] <= din;
			for (int i = 1; i < D; i++)
				sr_q[i] <= sr_q[i-1];
		end
	end

	assign dout = sr_q[D-1];

endmodule

[hdl/c2s_isqrt.sv]
module c2s_isqrt import c2s_pkg::*; (
	input  logic              clk,
	input  logic [63:0]       in_a,
	input  logic [63:0]       in_b,
	input  logic [63:0]       in_c,
	output logic [ISQ_W-1:0]  root
);

	logic [63:0]      rem_s  [ISQ_W+1];
	logic [ISQ_W-1:0] root_s [ISQ_W+1];

	always_ff @(posedge clk) begin
		rem_s[0]  <= in_a + in_b + in_c;
		root_s[0] <= '0;
	end

	// one root bit per stage, msb first
	for (genvar j = 0; j < ISQ_W; j++) begin : g_bit
		localparam int B = ISQ_W - 1 - j;
		logic [63:0] trial;
		assign trial = (64'(root_s[j]) << (B + 1)) + (64'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (rem_s[j] >= trial) begin
				rem_s[j+1]  <= rem_s[j] - trial;
				root_s[j+1] <= root_s[j] | (ISQ_W'(1) << B);
			end else begin
				rem_s[j+1]  <= rem_s[j];
				root_s[j+1] <= root_s[j];
			end
		end
	end

	assign root = root_s[ISQ_W];

endmodule

[hdl/c2s_cordic.sv]
module c2s_cordic import c2s_pkg::*; #(
	parameter int STEPS = 24
) (
	input  logic               clk,
	input  logic signed [34:0] in_xv,
	input  logic signed [34:0] in_yv,
	output logic signed [63:0] ang
);

	localparam int NS = 6 + STEPS;

	logic signed [63:0] x_s    [NS+1];
	logic signed [63:0] y_s    [NS+1];
	logic signed [63:0] ang_s  [NS+1];
	logic        [63:0] m_s    [7];
	logic               zero_s [NS+1];

	logic [34:0] ymag;
	logic [34:0] mmax;

	assign ymag = in_yv[34] ? 35'(-in_yv) : 35'(in_yv);
	assign mmax = (35'(in_xv) > ymag) ? 35'(in_xv) : ymag;

	always_ff @(posedge clk) begin
		x_s[0]    <= 64'(in_xv);
		y_s[0]    <= 64'(in_yv);
		m_s[0]    <= 64'(mmax);
		ang_s[0]  <= '0;
		zero_s[0] <= (in_yv == '0) || (mmax == '0);
	end

	// bring the larger magnitude up to bit 58
	for (genvar t = 0; t < 6; t++) begin : g_norm
		localparam int SH = 32 >> t;
		always_ff @(posedge clk) begin
			if (m_s[t] < (64'd1 << (59 - SH))) begin
				x_s[t+1] <= x_s[t] <<< SH;
				y_s[t+1] <= y_s[t] <<< SH;
				m_s[t+1] <= m_s[t] << SH;
			end else begin
				x_s[t+1] <= x_s[t];
				y_s[t+1] <= y_s[t];
				m_s[t+1] <= m_s[t];
			end
			ang_s[t+1]  <= '0;
			zero_s[t+1] <= zero_s[t];
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam int J = 6 + i;
		localparam logic signed [63:0] ATN = atan_q60(i);
		always_ff @(posedge clk) begin
			if (!y_s[J][63]) begin
				x_s[J+1]   <= x_s[J] + (y_s[J] >>> i);
				y_s[J+1]   <= y_s[J] - (x_s[J] >>> i);
				ang_s[J+1] <= ang_s[J] + ATN;
			end else begin
				x_s[J+1]   <= x_s[J] - (y_s[J] >>> i);
				y_s[J+1]   <= y_s[J] + (x_s[J] >>> i);
				ang_s[J+1] <= ang_s[J] - ATN;
			end
			zero_s[J+1] <= zero_s[J];
		end
	end

	assign ang = zero_s[NS] ? '0 : ang_s[NS];

endmodule

[hdl/c2s_deg.sv]
module c2s_deg import c2s_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic signed [63:0]      ang,
	input  logic signed [63:0]      offset,
	output logic signed [DEG_W-1:0] deg
);

	logic signed [63:0]      rr_s1;
	logic        [63:0]      mag_s2;
	logic        [63:0]      p00_s3, p01_s3, p10_s3, p11_s3;
	logic        [33:0]      mid_s4;
	logic        [63:0]      hi_s4;
	logic        [63:0]      q_s5;
	logic        [DEG_W-1:0] d_s6;
	logic                    neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic        [DEG_W-1:0] qs;

	assign qs = DEG_W'(q_s5 >> (52 - FRAC_BITS));

	always_ff @(posedge clk) begin
		rr_s1  <= ang + offset;
		neg_s2 <= rr_s1[63];
		mag_s2 <= rr_s1[63] ? 64'(-rr_s1) : 64'(rr_s1);
		p00_s3 <= mag_s2[31:0]  * TWO_OVER_PI_Q64[31:0];
		p01_s3 <= mag_s2[31:0]  * TWO_OVER_PI_Q64[63:32];
		p10_s3 <= mag_s2[63:32] * TWO_OVER_PI_Q64[31:0];
		p11_s3 <= mag_s2[63:32] * TWO_OVER_PI_Q64[63:32];
		neg_s3 <= neg_s2;
		mid_s4 <= 34'(p00_s3[63:32]) + 34'(p01_s3[31:0]) + 34'(p10_s3[31:0]);
		hi_s4  <= p11_s3 + 64'(p01_s3[63:32]) + 64'(p10_s3[63:32]);
		neg_s4 <= neg_s3;
		q_s5   <= hi_s4 + 64'(mid_s4[33:32]);
		neg_s5 <= neg_s4;
		d_s6   <= (qs * DEG_W'(90) + DEG_W'(128)) >> 8;
		neg_s6 <= neg_s5;
		deg    <= neg_s6 ? -$signed(d_s6) : $signed(d_s6);
	end

endmodule
